// ----- hw/rtl/slsu_pkg.sv -----
// ----------------------------------------------------------------------------
// slsu_pkg
// Shared opcodes, status codes, widths and the per-cell command type of the
// searchable LIFO stack.
// ----------------------------------------------------------------------------
package slsu_pkg;

    localparam int unsigned DEPTH_DEF = 16;
    localparam int unsigned VAL_W     = 32;
    localparam int unsigned OP_W      = 3;
    localparam int unsigned STAT_W    = 2;
    localparam int unsigned OCC_W     = 5;

    localparam logic [OP_W-1:0] OP_PUSH   = 3'd0;
    localparam logic [OP_W-1:0] OP_POP    = 3'd1;
    localparam logic [OP_W-1:0] OP_PEEK   = 3'd2;
    localparam logic [OP_W-1:0] OP_CLEAR  = 3'd3;
    localparam logic [OP_W-1:0] OP_SEARCH = 3'd4;
    localparam logic [OP_W-1:0] OP_REMOVE = 3'd5;
    localparam logic [OP_W-1:0] OP_EVENS  = 3'd6;
    localparam logic [OP_W-1:0] OP_DEDUP  = 3'd7;

    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

    // command to one stack cell
    typedef struct packed {
        logic init;       // load the hole bit from init_hole
        logic init_hole;
        logic load;       // write the push value
        logic kill;       // mark the entry as removed
        logic pair_up;    // compaction: paired with the cell above
        logic pair_down;  // compaction: paired with the cell below
    } t_cell_cmd;

endpackage

// ----- hw/rtl/slsu_if.sv -----
// ----------------------------------------------------------------------------
// slsu_req_if / slsu_rsp_if
// Valid/ready channels carrying stack requests and their results.
// ----------------------------------------------------------------------------
interface slsu_req_if;
    logic                               valid;
    logic                               ready;
    logic [slsu_pkg::OP_W-1:0]          opcode;
    logic signed [slsu_pkg::VAL_W-1:0]  value_in;

    modport source (output valid, output opcode, output value_in, input ready);
    modport sink   (input valid, input opcode, input value_in, output ready);
endinterface

interface slsu_rsp_if;
    logic                               valid;
    logic                               ready;
    logic signed [slsu_pkg::VAL_W-1:0]  value_out;
    logic                               hit_flag;
    logic [slsu_pkg::STAT_W-1:0]        status;
    logic [slsu_pkg::OCC_W-1:0]         occupancy;

    modport source (output valid, output value_out, output hit_flag, output status,
                    output occupancy, input ready);
    modport sink   (input valid, input value_out, input hit_flag, input status,
                    input occupancy, output ready);
endinterface

// ----- hw/rtl/slsu_cell.sv -----
// ----------------------------------------------------------------------------
// slsu_cell
// One stack entry: value, hole mark, key compare and one compaction swap
// step with its neighbor.
// ----------------------------------------------------------------------------
module slsu_cell (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  slsu_pkg::t_cell_cmd               i_cmd,
    input  logic signed [slsu_pkg::VAL_W-1:0] i_push_value,
    input  logic signed [slsu_pkg::VAL_W-1:0] i_key,
    input  logic signed [slsu_pkg::VAL_W-1:0] i_up_value,
    input  logic                              i_up_hole,
    input  logic                              i_down_hole,
    output logic signed [slsu_pkg::VAL_W-1:0] o_value,
    output logic                              o_hole,
    output logic                              o_eq
);

    logic signed [slsu_pkg::VAL_W-1:0] r_value;
    logic signed [slsu_pkg::VAL_W-1:0] n_value;
    logic                              r_hole;
    logic                              n_hole;

    always_comb begin
        n_value = r_value;
        n_hole  = r_hole;
        if (i_cmd.init) begin
            n_hole = i_cmd.init_hole;
        end
        if (i_cmd.load) begin
            n_value = i_push_value;
        end
        if (i_cmd.kill) begin
            n_hole = 1'b1;
        end
        // live entry above a hole sinks by one place
        if (i_cmd.pair_up && r_hole && !i_up_hole) begin
            n_value = i_up_value;
            n_hole  = 1'b0;
        end
        if (i_cmd.pair_down && !r_hole && i_down_hole) begin
            n_hole = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        if (!i_rst_n) begin
            r_hole <= 1'b1;
        end else begin
            r_hole <= n_hole;
        end
    end

    assign o_value = r_value;
    assign o_hole  = r_hole;
    assign o_eq    = (r_value == i_key);

endmodule

// ----- hw/rtl/searchable_lifo_stack_unit.sv -----
// ----------------------------------------------------------------------------
// searchable_lifo_stack_unit
// Bounded LIFO stack of signed 32-bit values with search, remove-value,
// remove-evens and remove-duplicates, built as a row of DEPTH cells.
// ----------------------------------------------------------------------------
// Push, pop, peek and clear, and any search or remove on an empty stack,
// are completed in the idle state. Search, remove value, remove evens and
// remove duplicates walk a pointer from the top cell to the bottom,
// broadcasting one cell's value to the row per cycle; when entries were
// removed, an odd-even compaction over the row follows the walk. One
// request is worked on at a time; the result sits in an output register,
// and the next request is taken as soon as the block is idle and that
// register is free or being read.
// ----------------------------------------------------------------------------
module searchable_lifo_stack_unit #(
    parameter int unsigned DEPTH = slsu_pkg::DEPTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    slsu_req_if.sink     i_req,
    slsu_rsp_if.source   o_rsp
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_PACK = 2'd2;

    logic [1:0]                        r_state, n_state;
    logic [CW-1:0]                     r_count, n_count;
    logic [PW-1:0]                     r_ptr, n_ptr;
    logic [PW-1:0]                     r_step, n_step;
    logic [CW-1:0]                     r_kcnt, n_kcnt;
    logic                              r_hit, n_hit;
    logic [slsu_pkg::OP_W-1:0]         r_op, n_op;
    logic signed [slsu_pkg::VAL_W-1:0] r_key, n_key;

    logic                              r_ov, n_ov;
    logic signed [slsu_pkg::VAL_W-1:0] r_vout, n_vout;
    logic                              r_hout, n_hout;
    logic [slsu_pkg::STAT_W-1:0]       r_sout, n_sout;
    logic [slsu_pkg::OCC_W-1:0]        r_occ, n_occ;

    logic signed [slsu_pkg::VAL_W-1:0] cell_val  [DEPTH];
    logic                              cell_hole [DEPTH];
    logic                              cell_eq   [DEPTH];
    slsu_pkg::t_cell_cmd               cell_cmd  [DEPTH];

    logic                              req_fire;
    logic                              rsp_fire;
    logic                              is_empty;
    logic                              is_full;
    logic [PW-1:0]                     top_idx;
    logic signed [slsu_pkg::VAL_W-1:0] top_value;
    logic signed [slsu_pkg::VAL_W-1:0] bcast;
    logic                              scan_on;
    logic                              live_p;
    logic                              key_hit;
    logic                              kill_ptr;
    logic                              ptr_gone;
    logic                              dedup_on;
    logic                              init_on;
    logic                              push_on;
    logic                              phase;
    logic [CW-1:0]                     kcnt_sum;

    assign req_fire  = i_req.valid && i_req.ready;
    assign rsp_fire  = o_rsp.valid && o_rsp.ready;
    assign is_empty  = (r_count == '0);
    assign is_full   = (r_count >= CW'(DEPTH));
    assign top_idx   = PW'(r_count - CW'(1));
    assign top_value = cell_val[top_idx];
    assign bcast     = cell_val[r_ptr];
    assign scan_on   = (r_state == ST_SCAN);
    assign live_p    = (CW'(r_ptr) < r_count);
    assign key_hit   = (bcast == r_key);
    assign phase     = r_step[0];

    // removal decided at the pointer cell for remove value and remove evens
    assign kill_ptr = scan_on && live_p &&
                      (((r_op == slsu_pkg::OP_REMOVE) && key_hit && !r_hit) ||
                       ((r_op == slsu_pkg::OP_EVENS) && !bcast[0]));
    // cells above the pointer are final, so its hole mark counts now
    assign ptr_gone = live_p && (kill_ptr || cell_hole[r_ptr]);
    assign kcnt_sum = r_kcnt + CW'(ptr_gone);
    assign dedup_on = scan_on && live_p && (r_op == slsu_pkg::OP_DEDUP);
    assign init_on  = req_fire && !is_empty &&
                      (i_req.opcode inside {slsu_pkg::OP_SEARCH, slsu_pkg::OP_REMOVE,
                                            slsu_pkg::OP_EVENS, slsu_pkg::OP_DEDUP});
    assign push_on  = req_fire && (i_req.opcode == slsu_pkg::OP_PUSH) && !is_full;

    for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
        localparam logic PAR    = 1'(gi % 2);
        localparam logic HAS_UP = (gi < DEPTH - 1);
        localparam logic HAS_DN = (gi > 0);

        logic signed [slsu_pkg::VAL_W-1:0] up_value;
        logic                              up_hole;
        logic                              down_hole;

        if (HAS_UP) begin : g_up
            assign up_value = cell_val[gi + 1];
            assign up_hole  = cell_hole[gi + 1];
        end else begin : g_top
            assign up_value = '0;
            assign up_hole  = 1'b1;
        end

        if (HAS_DN) begin : g_dn
            assign down_hole = cell_hole[gi - 1];
        end else begin : g_bot
            assign down_hole = 1'b0;
        end

        always_comb begin
            cell_cmd[gi].init      = init_on;
            cell_cmd[gi].init_hole = (CW'(gi) >= r_count);
            cell_cmd[gi].load      = push_on && (CW'(gi) == r_count);
            cell_cmd[gi].kill      = (kill_ptr && (PW'(gi) == r_ptr)) ||
                                     (dedup_on && (PW'(gi) < r_ptr) && cell_eq[gi]);
            cell_cmd[gi].pair_up   = (r_state == ST_PACK) && HAS_UP && (PAR == phase);
            cell_cmd[gi].pair_down = (r_state == ST_PACK) && HAS_DN && (PAR != phase);
        end

        slsu_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_cmd        (cell_cmd[gi]),
            .i_push_value (i_req.value_in),
            .i_key        (bcast),
            .i_up_value   (up_value),
            .i_up_hole    (up_hole),
            .i_down_hole  (down_hole),
            .o_value      (cell_val[gi]),
            .o_hole       (cell_hole[gi]),
            .o_eq         (cell_eq[gi])
        );
    end

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_ptr   = r_ptr;
        n_step  = r_step;
        n_kcnt  = r_kcnt;
        n_hit   = r_hit;
        n_op    = r_op;
        n_key   = r_key;
        n_ov    = r_ov;
        n_vout  = r_vout;
        n_hout  = r_hout;
        n_sout  = r_sout;
        n_occ   = r_occ;

        if (rsp_fire) begin
            n_ov = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (req_fire) begin
                    n_ov   = 1'b1;
                    n_vout = '0;
                    n_hout = 1'b0;
                    n_sout = slsu_pkg::STAT_OK;
                    unique case (i_req.opcode) inside
                        slsu_pkg::OP_PUSH: begin
                            if (is_full) begin
                                n_sout = slsu_pkg::STAT_FULL;
                            end else begin
                                n_count = r_count + CW'(1);
                            end
                        end
                        slsu_pkg::OP_POP: begin
                            if (is_empty) begin
                                n_sout = slsu_pkg::STAT_EMPTY;
                            end else begin
                                n_vout  = top_value;
                                n_count = r_count - CW'(1);
                            end
                        end
                        slsu_pkg::OP_PEEK: begin
                            if (is_empty) begin
                                n_sout = slsu_pkg::STAT_EMPTY;
                            end else begin
                                n_vout = top_value;
                            end
                        end
                        slsu_pkg::OP_CLEAR: begin
                            n_count = '0;
                        end
                        slsu_pkg::OP_SEARCH, slsu_pkg::OP_REMOVE,
                        slsu_pkg::OP_EVENS, slsu_pkg::OP_DEDUP: begin
                            if (is_empty) begin
                                n_sout = slsu_pkg::STAT_EMPTY;
                            end else begin
                                n_ov    = 1'b0;
                                n_state = ST_SCAN;
                                n_ptr   = PW'(DEPTH - 1);
                                n_kcnt  = '0;
                                n_hit   = (i_req.opcode == slsu_pkg::OP_DEDUP);
                                n_op    = i_req.opcode;
                                n_key   = i_req.value_in;
                            end
                        end
                        default: begin
                        end
                    endcase
                    n_occ = slsu_pkg::OCC_W'(n_count);
                end
            end
            ST_SCAN: begin
                if ((r_op == slsu_pkg::OP_SEARCH) && live_p && key_hit) begin
                    n_hit = 1'b1;
                end
                if (kill_ptr) begin
                    n_hit = 1'b1;
                end
                n_kcnt = kcnt_sum;
                if (r_ptr == '0) begin
                    if (kcnt_sum == '0) begin
                        n_state = ST_IDLE;
                        n_ov    = 1'b1;
                        n_vout  = '0;
                        n_hout  = n_hit;
                        n_sout  = slsu_pkg::STAT_OK;
                        n_occ   = slsu_pkg::OCC_W'(r_count);
                    end else begin
                        n_state = ST_PACK;
                        n_step  = '0;
                    end
                end else begin
                    n_ptr = r_ptr - PW'(1);
                end
            end
            ST_PACK: begin
                n_step = r_step + PW'(1);
                if (r_step == PW'(DEPTH - 1)) begin
                    n_count = r_count - r_kcnt;
                    n_state = ST_IDLE;
                    n_ov    = 1'b1;
                    n_vout  = '0;
                    n_hout  = r_hit;
                    n_sout  = slsu_pkg::STAT_OK;
                    n_occ   = slsu_pkg::OCC_W'(n_count);
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_ptr  <= n_ptr;
        r_step <= n_step;
        r_kcnt <= n_kcnt;
        r_hit  <= n_hit;
        r_op   <= n_op;
        r_key  <= n_key;
        r_vout <= n_vout;
        r_hout <= n_hout;
        r_sout <= n_sout;
        r_occ  <= n_occ;
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_ov    <= n_ov;
        end
    end

    assign i_req.ready     = (r_state == ST_IDLE) && (!r_ov || o_rsp.ready);
    assign o_rsp.valid     = r_ov;
    assign o_rsp.value_out = r_vout;
    assign o_rsp.hit_flag  = r_hout;
    assign o_rsp.status    = r_sout;
    assign o_rsp.occupancy = r_occ;

endmodule

// ----- verif/searchable_lifo_stack_unit_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// searchable_lifo_stack_unit_test
// Self-checking bench for the searchable LIFO stack. A shadow stack predicts
// every result when its request is taken. Requests come from a queue: a
// directed opening, then random bursts of fills, drains and mixed edits
// drawn from small value pools. Both handshakes idle at random.
// ----------------------------------------------------------------------------
module searchable_lifo_stack_unit_test;

    localparam int STACK_DEPTH  = slsu_pkg::DEPTH_DEF;
    localparam int RANDOM_REQS  = 1500;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int CALM_FIRST   = 2000;
    localparam int CALM_LAST    = 4000;
    localparam int IDLE_PERCENT = 31;
    localparam int TAIL_CYCLES  = 2 * STACK_DEPTH + 8;

    typedef struct {
        logic [slsu_pkg::OP_W-1:0]          op;
        logic signed [slsu_pkg::VAL_W-1:0]  val;
        bit                                 drain_first;
    } t_stack_req;

    typedef struct packed {
        logic signed [slsu_pkg::VAL_W-1:0]  value_out;
        logic                               hit_flag;
        logic [slsu_pkg::STAT_W-1:0]        status;
        logic [slsu_pkg::OCC_W-1:0]         occupancy;
    } t_stack_rsp;

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   cyc = 0;
    int   fails = 0;

    slsu_req_if req_if ();
    slsu_rsp_if rsp_if ();

    searchable_lifo_stack_unit #(
        .DEPTH (STACK_DEPTH)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    t_stack_req                        pending_reqs[$];
    t_stack_rsp                        expected_rsps[$];
    logic signed [slsu_pkg::VAL_W-1:0] shadow_cells[STACK_DEPTH];
    int                                shadow_count = 0;
    logic signed [slsu_pkg::VAL_W-1:0] value_pool[6];

    t_stack_req                        next_req;
    t_stack_rsp                        got_rsp;
    t_stack_rsp                        want_rsp;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cyc <= cyc + 1;
    end

    function automatic bit idle_now();
        if (cyc >= CALM_FIRST && cyc < CALM_LAST) begin
            return 1'b0;
        end
        return $urandom_range(0, 99) < IDLE_PERCENT;
    endfunction

    // shadow stack: applies one request and returns its result
    function automatic t_stack_rsp stack_apply(logic [slsu_pkg::OP_W-1:0] op,
                                               logic signed [slsu_pkg::VAL_W-1:0] val);
        t_stack_rsp                        r;
        logic signed [slsu_pkg::VAL_W-1:0] kept[STACK_DEPTH];
        int                                n;
        bit                                dup;
        r = '0;
        n = 0;
        if (op == slsu_pkg::OP_PUSH) begin
            if (shadow_count >= STACK_DEPTH) begin
                r.status = slsu_pkg::STAT_FULL;
            end else begin
                shadow_cells[shadow_count] = val;
                shadow_count++;
            end
        end else if (op == slsu_pkg::OP_CLEAR) begin
            shadow_count = 0;
        end else if (shadow_count == 0) begin
            r.status = slsu_pkg::STAT_EMPTY;
        end else begin
            case (op)
                slsu_pkg::OP_POP: begin
                    r.value_out = shadow_cells[shadow_count-1];
                    shadow_count--;
                end
                slsu_pkg::OP_PEEK: begin
                    r.value_out = shadow_cells[shadow_count-1];
                end
                slsu_pkg::OP_SEARCH: begin
                    for (int i = 0; i < shadow_count; i++) begin
                        if (shadow_cells[i] == val) r.hit_flag = 1'b1;
                    end
                end
                slsu_pkg::OP_REMOVE: begin
                    // topmost copy only
                    for (int i = shadow_count - 1; i >= 0; i--) begin
                        if (!r.hit_flag && shadow_cells[i] == val) begin
                            r.hit_flag = 1'b1;
                            for (int j = i; j + 1 < shadow_count; j++) begin
                                shadow_cells[j] = shadow_cells[j+1];
                            end
                            shadow_count--;
                        end
                    end
                end
                slsu_pkg::OP_EVENS: begin
                    for (int i = 0; i < shadow_count; i++) begin
                        if (shadow_cells[i][0] == 1'b0) begin
                            r.hit_flag = 1'b1;
                        end else begin
                            kept[n] = shadow_cells[i];
                            n++;
                        end
                    end
                    for (int i = 0; i < n; i++) shadow_cells[i] = kept[i];
                    shadow_count = n;
                end
                slsu_pkg::OP_DEDUP: begin
                    // keep an entry only when no copy lies above it
                    for (int i = 0; i < shadow_count; i++) begin
                        dup = 1'b0;
                        for (int j = i + 1; j < shadow_count; j++) begin
                            if (shadow_cells[j] == shadow_cells[i]) dup = 1'b1;
                        end
                        if (!dup) begin
                            kept[n] = shadow_cells[i];
                            n++;
                        end
                    end
                    for (int i = 0; i < n; i++) shadow_cells[i] = kept[i];
                    shadow_count = n;
                    r.hit_flag = 1'b1;
                end
                default: begin
                end
            endcase
        end
        r.occupancy = slsu_pkg::OCC_W'(shadow_count);
        return r;
    endfunction

    task automatic add_req(logic [slsu_pkg::OP_W-1:0] op,
                           logic signed [slsu_pkg::VAL_W-1:0] val,
                           bit drain_first = 1'b0);
        t_stack_req q;
        q.op          = op;
        q.val         = val;
        q.drain_first = drain_first;
        pending_reqs.push_back(q);
    endtask

    task automatic refresh_pool();
        for (int k = 0; k < 6; k++) begin
            if ($urandom_range(0, 1)) begin
                value_pool[k] = $urandom;
            end else begin
                value_pool[k] = $signed($urandom_range(0, 15)) - 8;
            end
        end
    endtask

    function automatic logic signed [slsu_pkg::VAL_W-1:0] pick_value();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 65) return value_pool[$urandom_range(0, 5)];
        if (sel < 85) return $urandom;
        case ($urandom_range(0, 3))
            0:       return 32'sh7FFFFFFF;
            1:       return 32'sh80000000;
            2:       return '0;
            default: return -1;
        endcase
    endfunction

    function automatic logic [slsu_pkg::OP_W-1:0] pick_op();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 35) return slsu_pkg::OP_PUSH;
        if (sel < 45) return slsu_pkg::OP_POP;
        if (sel < 53) return slsu_pkg::OP_PEEK;
        if (sel < 56) return slsu_pkg::OP_CLEAR;
        if (sel < 70) return slsu_pkg::OP_SEARCH;
        if (sel < 84) return slsu_pkg::OP_REMOVE;
        if (sel < 92) return slsu_pkg::OP_EVENS;
        return slsu_pkg::OP_DEDUP;
    endfunction

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else begin
            if (req_if.valid && req_if.ready) begin
                expected_rsps.push_back(stack_apply(req_if.opcode, req_if.value_in));
            end
            if (!req_if.valid || req_if.ready) begin
                if (pending_reqs.size() != 0 && !idle_now() &&
                    !(pending_reqs[0].drain_first && expected_rsps.size() != 0)) begin
                    next_req = pending_reqs.pop_front();
                    req_if.valid    <= 1'b1;
                    req_if.opcode   <= next_req.op;
                    req_if.value_in <= next_req.val;
                end else begin
                    req_if.valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
        end else begin
            if (rsp_if.valid && rsp_if.ready) begin
                got_rsp.value_out = rsp_if.value_out;
                got_rsp.hit_flag  = rsp_if.hit_flag;
                got_rsp.status    = rsp_if.status;
                got_rsp.occupancy = rsp_if.occupancy;
                if (expected_rsps.size() == 0) begin
                    $error("result with no request outstanding: value_out %0d",
                           got_rsp.value_out);
                    fails++;
                end else begin
                    want_rsp = expected_rsps.pop_front();
                    if (got_rsp.value_out !== want_rsp.value_out) begin
                        $error("value_out expected %0d actual %0d",
                               want_rsp.value_out, got_rsp.value_out);
                        fails++;
                    end
                    if (got_rsp.hit_flag !== want_rsp.hit_flag) begin
                        $error("hit_flag expected %0d actual %0d",
                               want_rsp.hit_flag, got_rsp.hit_flag);
                        fails++;
                    end
                    if (got_rsp.status !== want_rsp.status) begin
                        $error("status expected %0d actual %0d",
                               want_rsp.status, got_rsp.status);
                        fails++;
                    end
                    if (got_rsp.occupancy !== want_rsp.occupancy) begin
                        $error("occupancy expected %0d actual %0d",
                               want_rsp.occupancy, got_rsp.occupancy);
                        fails++;
                    end
                end
            end
            rsp_if.ready <= !idle_now();
        end
    end

    initial begin
        wait (cyc >= CYCLE_LIMIT);
        $display("searchable_lifo_stack_unit verification failed");
        $finish;
    end

    initial begin
        int kind;
        int len;
        int made;
        i_rst_n = 1'b0;

        // empty stack cases
        add_req(slsu_pkg::OP_POP,    32'sh5A5A5A5A);
        add_req(slsu_pkg::OP_PEEK,   '0);
        add_req(slsu_pkg::OP_SEARCH, '0);
        add_req(slsu_pkg::OP_REMOVE, -1);
        add_req(slsu_pkg::OP_EVENS,  '0);
        add_req(slsu_pkg::OP_DEDUP,  '0);
        add_req(slsu_pkg::OP_CLEAR,  '0);
        // extremes, negative even and odd, a duplicate
        add_req(slsu_pkg::OP_PUSH,   32'sh7FFFFFFF);
        add_req(slsu_pkg::OP_PUSH,   32'sh80000000);
        add_req(slsu_pkg::OP_PUSH,   -1);
        add_req(slsu_pkg::OP_PUSH,   '0);
        add_req(slsu_pkg::OP_PUSH,   -2);
        add_req(slsu_pkg::OP_PUSH,   3, 1'b1);
        add_req(slsu_pkg::OP_PUSH,   32'sh7FFFFFFF);
        add_req(slsu_pkg::OP_SEARCH, 32'sh80000000);
        add_req(slsu_pkg::OP_SEARCH, 5);
        add_req(slsu_pkg::OP_REMOVE, 32'sh7FFFFFFF);
        add_req(slsu_pkg::OP_REMOVE, 12345);
        add_req(slsu_pkg::OP_PEEK,   '0);
        add_req(slsu_pkg::OP_DEDUP,  '0);
        add_req(slsu_pkg::OP_EVENS,  '0);
        add_req(slsu_pkg::OP_EVENS,  '0);
        add_req(slsu_pkg::OP_POP,    '0);
        add_req(slsu_pkg::OP_POP,    '0);
        add_req(slsu_pkg::OP_CLEAR,  '0);

        refresh_pool();
        made = 0;
        while (made < RANDOM_REQS) begin
            kind = $urandom_range(0, 9);
            if ($urandom_range(0, 3) == 0) refresh_pool();
            if (kind < 2) begin
                // 18 pushes always reach full, whatever the occupancy
                for (int k = 0; k < 18; k++) add_req(slsu_pkg::OP_PUSH, pick_value());
                made += 18;
            end else if (kind == 2) begin
                len = $urandom_range(1, 18);
                for (int k = 0; k < len; k++) begin
                    add_req($urandom_range(0, 3) == 0 ? slsu_pkg::OP_PEEK : slsu_pkg::OP_POP,
                            $urandom);
                end
                made += len;
            end else begin
                len = $urandom_range(4, 20);
                for (int k = 0; k < len; k++) begin
                    add_req(pick_op(), pick_value(), $urandom_range(0, 199) == 0);
                end
                made += len;
            end
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do begin
            @(posedge i_clk);
        end while (pending_reqs.size() != 0 || req_if.valid || expected_rsps.size() != 0);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (fails == 0) begin
            $display("searchable_lifo_stack_unit verification clean");
        end else begin
            $display("searchable_lifo_stack_unit verification failed");
        end
        $finish;
    end

endmodule
